@@ rtl/ast_pkg.sv @@
// Shared types, character codes and directive-word tables for the source tokenizer.
package ast_pkg;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_COMMENT = 3'd1,
    M_STRING  = 3'd2,
    M_ESCAPE  = 3'd3,
    M_MINUS   = 3'd4,
    M_NUMBER  = 3'd5,
    M_IDENT   = 3'd6
  } scan_mode_e;

  localparam logic [2:0] TK_EOF     = 3'd0;
  localparam logic [2:0] TK_NEWLINE = 3'd1;
  localparam logic [2:0] TK_COMMA   = 3'd2;
  localparam logic [2:0] TK_COLON   = 3'd3;
  localparam logic [2:0] TK_STRING  = 3'd4;
  localparam logic [2:0] TK_NUMBER  = 3'd5;
  localparam logic [2:0] TK_DIRECT  = 3'd6;
  localparam logic [2:0] TK_IDENT   = 3'd7;

  localparam logic REC_TEXT = 1'b0;
  localparam logic REC_DONE = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UPX   = 8'h58;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LOWN  = 8'h6E;
  localparam logic [7:0] CH_LOWR  = 8'h72;
  localparam logic [7:0] CH_LOWT  = 8'h74;
  localparam logic [7:0] CH_LOWX  = 8'h78;

  localparam logic [1:0] BASE_8  = 2'd0;
  localparam logic [1:0] BASE_10 = 2'd1;
  localparam logic [1:0] BASE_16 = 2'd2;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic        kind;
    logic [2:0]  ttype;
    logic [7:0]  text;
    logic [31:0] line;
    logic [5:0]  len;
  } rec_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [63:0] acc;
    logic        neg;
    logic        stop;
    logic        ovf;
  } num_t;

  function automatic logic [63:0] kw_word(input logic [2:0] i);
    logic [63:0] w;
    case (i)
      3'd0:    w = 64'h676C_6F62_616C_0000; // global
      3'd1:    w = 64'h7365_6374_696F_6E00; // section
      3'd2:    w = 64'h6462_0000_0000_0000; // db
      3'd3:    w = 64'h6578_7465_726E_0000; // extern
      3'd4:    w = 64'h7265_7362_0000_0000; // resb
      3'd5:    w = 64'h7265_7377_0000_0000; // resw
      3'd6:    w = 64'h7265_7364_0000_0000; // resd
      default: w = 64'h7265_7371_0000_0000; // resq
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] i);
    logic [3:0] n;
    case (i)
      3'd0:    n = 4'd6;
      3'd1:    n = 4'd7;
      3'd2:    n = 4'd2;
      3'd3:    n = 4'd6;
      default: n = 4'd4;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] i, input logic [2:0] pos);
    logic [63:0] w;
    w = kw_word(i);
    return w[63 - 8 * pos -: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // 16 marks a byte that is no hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    if (is_digit(c)) v = 5'(c - 8'h30);
    else if ((c >= 8'h61) && (c <= 8'h66)) v = 5'(c - 8'h57);
    else if ((c >= 8'h41) && (c <= 8'h46)) v = 5'(c - 8'h37);
    else v = 5'd16;
    return v;
  endfunction

  // acc*base + d > limit is the same test as acc > (limit - d) / base
  function automatic num_t add_digit(input num_t s, input logic [1:0] base,
                                     input logic [4:0] d);
    num_t        r;
    logic [67:0] wide;
    logic [67:0] lim;
    r = s;
    case (base)
      BASE_8:  wide = {4'b0, s.acc} << 3;
      BASE_10: wide = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1);
      default: wide = {4'b0, s.acc} << 4;
    endcase
    wide = wide + 68'(d);
    lim  = s.neg ? {4'b0, NEG_LIMIT} : {4'b0, POS_LIMIT};
    if (!s.ovf) begin
      if (wide > lim) r.ovf = 1'b1;
      else r.acc = wide[63:0];
    end
    return r;
  endfunction

  function automatic num_t num_digit(input num_t s, input logic [7:0] c);
    num_t       r;
    logic [4:0] d;
    r = s;
    d = hex_val(c);
    if (!s.stop) begin
      case (s.phase)
        3'd0: begin
          if (c == CH_ZERO) r.phase = 3'd1;
          else if (d < 5'd10) begin
            r = add_digit(s, BASE_10, d);
            r.phase = 3'd3;
          end else r.stop = 1'b1;
        end
        3'd1: begin
          if (c == CH_LOWX || c == CH_UPX) r.phase = 3'd2;
          else if (d < 5'd8) begin
            r = add_digit(s, BASE_8, d);
            r.phase = 3'd4;
          end else r.stop = 1'b1;
        end
        3'd2: begin
          if (d < 5'd16) begin
            r = add_digit(s, BASE_16, d);
            r.phase = 3'd5;
          end else r.stop = 1'b1;
        end
        3'd3: begin
          if (d < 5'd10) r = add_digit(s, BASE_10, d);
          else r.stop = 1'b1;
        end
        3'd4: begin
          if (d < 5'd8) r = add_digit(s, BASE_8, d);
          else r.stop = 1'b1;
        end
        default: begin
          if (d < 5'd16) r = add_digit(s, BASE_16, d);
          else r.stop = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

endpackage

@@ rtl/assembly_source_tokenizer.sv @@
// Assembly source tokenizer: one source byte per beat in, text and token records out.
// The records of a byte are registered; the first is offered the cycle after the byte is taken.
// One byte per cycle while each byte yields at most one record and out_ready_i is high; a byte
//   that yields N records (up to 5) holds the input while the record buffer drains.
// Reset: asynchronous, active low; scanner idle, line counter 1, record buffer empty.
module assembly_source_tokenizer #(
  parameter int TEXT_CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         source_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               record_kind_o,
  output logic [2:0]         token_type_o,
  output logic [7:0]         text_byte_o,
  output logic [31:0]        token_line_o,
  output logic signed [63:0] number_value_o,
  output logic [5:0]         text_length_o,
  output logic               last_of_run_o
);

  localparam int KLW = $clog2(TEXT_CAPACITY);
  localparam logic [KLW-1:0] KEEP_MAX = KLW'(TEXT_CAPACITY - 1);
  localparam int NREC = 5;

  ast_pkg::scan_mode_e mode_q, mode_d;
  logic                quote_q, quote_d;
  logic [31:0]         line_q, line_d;
  logic [31:0]         start_q, start_d;
  logic [KLW-1:0]      klen_q, klen_d;
  logic [7:0]          kcand_q, kcand_d;
  ast_pkg::num_t       num_q, num_d;

  ast_pkg::rec_t       rec_q [NREC];
  ast_pkg::rec_t       rec_d [NREC];
  logic [2:0]          cnt_q, cnt_d;
  logic [2:0]          idx_q;
  logic [63:0]         val_q, val_d;

  logic in_fire, out_fire, buf_empty, at_last;

  assign buf_empty  = idx_q >= cnt_q;
  assign at_last    = (idx_q + 3'd1) == cnt_q;
  assign in_ready_o = buf_empty || (out_ready_i && at_last);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = !buf_empty;
  assign out_fire   = out_valid_o && out_ready_i;

  always_comb begin
    logic [7:0]  c;
    logic [7:0]  e;
    logic [7:0]  q;
    logic [2:0]  tt;
    logic        idle_go;
    logic        dir;
    logic [63:0] v;
    logic [2:0]  n;
    c       = source_byte_i;
    e       = c;
    q       = ast_pkg::CH_DQUOT;
    tt      = ast_pkg::TK_IDENT;
    idle_go = 1'b0;
    dir     = 1'b0;
    v       = 64'd0;
    n       = 3'd0;
    mode_d  = mode_q;
    quote_d = quote_q;
    line_d  = line_q;
    start_d = start_q;
    klen_d  = klen_q;
    kcand_d = kcand_q;
    num_d   = num_q;
    val_d   = 64'd0;
    for (int i = 0; i < NREC; i++) rec_d[i] = '0;

    case (mode_q)
      ast_pkg::M_COMMENT: begin
        if (c == ast_pkg::CH_LF || c == ast_pkg::CH_NUL) idle_go = 1'b1;
      end
      ast_pkg::M_STRING: begin
        q = quote_q ? ast_pkg::CH_SQUOT : ast_pkg::CH_DQUOT;
        if (c == q) begin
          rec_d[n] = '{ast_pkg::REC_DONE, ast_pkg::TK_STRING, 8'd0, start_d, 6'(klen_d)};
          n = n + 3'd1;
          mode_d = ast_pkg::M_IDLE;
        end else if (c == ast_pkg::CH_NUL) begin
          rec_d[n] = '{ast_pkg::REC_DONE, ast_pkg::TK_STRING, 8'd0, start_d, 6'(klen_d)};
          n = n + 3'd1;
          idle_go = 1'b1;
        end else if (c == ast_pkg::CH_BSL) begin
          mode_d = ast_pkg::M_ESCAPE;
        end else begin
          if (klen_d < KEEP_MAX) begin
            rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_STRING, c, start_d, 6'd0};
            n = n + 3'd1;
            klen_d = klen_d + 1'b1;
          end
          if (c == ast_pkg::CH_LF && line_d != '1) line_d = line_d + 32'd1;
        end
      end
      ast_pkg::M_ESCAPE: begin
        if (c == ast_pkg::CH_NUL) begin
          if (klen_d < KEEP_MAX) begin
            rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_STRING, 8'd0, start_d, 6'd0};
            n = n + 3'd1;
            klen_d = klen_d + 1'b1;
          end
          rec_d[n] = '{ast_pkg::REC_DONE, ast_pkg::TK_STRING, 8'd0, start_d, 6'(klen_d)};
          n = n + 3'd1;
          idle_go = 1'b1;
        end else begin
          if (c == ast_pkg::CH_LOWN) e = ast_pkg::CH_LF;
          else if (c == ast_pkg::CH_LOWT) e = ast_pkg::CH_TAB;
          else if (c == ast_pkg::CH_LOWR) e = ast_pkg::CH_CR;
          else if (c == ast_pkg::CH_ZERO) e = ast_pkg::CH_NUL;
          if (klen_d < KEEP_MAX) begin
            rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_STRING, e, start_d, 6'd0};
            n = n + 3'd1;
            klen_d = klen_d + 1'b1;
          end
          if (c == ast_pkg::CH_LF && line_d != '1) line_d = line_d + 32'd1;
          mode_d = ast_pkg::M_STRING;
        end
      end
      ast_pkg::M_MINUS: begin
        if (ast_pkg::is_digit(c)) begin
          mode_d = ast_pkg::M_NUMBER;
          num_d.neg = 1'b1;
          if (klen_d < KEEP_MAX) begin
            rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_NUMBER, ast_pkg::CH_MINUS,
                         start_d, 6'd0};
            n = n + 3'd1;
            klen_d = klen_d + 1'b1;
          end
          if (klen_d < KEEP_MAX) begin
            rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_NUMBER, c, start_d, 6'd0};
            n = n + 3'd1;
            klen_d = klen_d + 1'b1;
            num_d = ast_pkg::num_digit(num_d, c);
          end
        end else begin
          if (klen_d < KEEP_MAX) begin
            rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_IDENT, ast_pkg::CH_MINUS,
                         start_d, 6'd0};
            n = n + 3'd1;
            klen_d = klen_d + 1'b1;
          end
          rec_d[n] = '{ast_pkg::REC_DONE, ast_pkg::TK_IDENT, 8'd0, start_d, 6'(klen_d)};
          n = n + 3'd1;
          idle_go = 1'b1;
        end
      end
      ast_pkg::M_NUMBER: begin
        if (ast_pkg::hex_val(c) < 5'd16 || c == ast_pkg::CH_LOWX || c == ast_pkg::CH_UPX) begin
          if (klen_d < KEEP_MAX) begin
            rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_NUMBER, c, start_d, 6'd0};
            n = n + 3'd1;
            klen_d = klen_d + 1'b1;
            num_d = ast_pkg::num_digit(num_d, c);
          end
        end else begin
          if (num_q.ovf) v = num_q.neg ? ast_pkg::NEG_LIMIT : ast_pkg::POS_LIMIT;
          else v = num_q.neg ? (64'd0 - num_q.acc) : num_q.acc;
          val_d = v;
          rec_d[n] = '{ast_pkg::REC_DONE, ast_pkg::TK_NUMBER, 8'd0, start_d, 6'(klen_d)};
          n = n + 3'd1;
          idle_go = 1'b1;
        end
      end
      ast_pkg::M_IDENT: begin
        if (ast_pkg::is_alpha(c) || ast_pkg::is_digit(c) || c == ast_pkg::CH_UNDER ||
            c == ast_pkg::CH_DOT) begin
          if (klen_d < KEEP_MAX) begin
            for (int i = 0; i < 8; i++) begin
              if (32'(klen_d) >= 32'(ast_pkg::kw_len(3'(i))) ||
                  ast_pkg::kw_char(3'(i), 3'(klen_d)) != c) kcand_d[i] = 1'b0;
            end
            rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_IDENT, c, start_d, 6'd0};
            n = n + 3'd1;
            klen_d = klen_d + 1'b1;
          end
        end else begin
          for (int i = 0; i < 8; i++) begin
            if (kcand_q[i] && 32'(klen_q) == 32'(ast_pkg::kw_len(3'(i)))) dir = 1'b1;
          end
          rec_d[n] = '{ast_pkg::REC_DONE, dir ? ast_pkg::TK_DIRECT : ast_pkg::TK_IDENT,
                       8'd0, start_d, 6'(klen_d)};
          n = n + 3'd1;
          idle_go = 1'b1;
        end
      end
      default: idle_go = 1'b1;
    endcase

    // Byte that ended (or never joined) a token is scanned from idle in the same beat
    if (idle_go) begin
      mode_d = ast_pkg::M_IDLE;
      if (c == ast_pkg::CH_NUL) begin
        start_d = line_d;
        rec_d[n] = '{ast_pkg::REC_DONE, ast_pkg::TK_EOF, 8'd0, start_d, 6'd0};
        n = n + 3'd1;
      end else if (c == ast_pkg::CH_SPACE || c == ast_pkg::CH_TAB || c == ast_pkg::CH_CR) begin
        mode_d = ast_pkg::M_IDLE;
      end else if (c == ast_pkg::CH_SEMI) begin
        mode_d = ast_pkg::M_COMMENT;
      end else begin
        start_d = line_d;
        klen_d  = '0;
        kcand_d = 8'hFF;
        num_d   = '0;
        if (c == ast_pkg::CH_DQUOT || c == ast_pkg::CH_SQUOT) begin
          mode_d  = ast_pkg::M_STRING;
          quote_d = (c == ast_pkg::CH_SQUOT);
        end else if (ast_pkg::is_digit(c)) begin
          mode_d = ast_pkg::M_NUMBER;
          rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_NUMBER, c, start_d, 6'd0};
          n = n + 3'd1;
          klen_d = klen_d + 1'b1;
          num_d = ast_pkg::num_digit(num_d, c);
        end else if (c == ast_pkg::CH_MINUS) begin
          mode_d = ast_pkg::M_MINUS;
        end else if (ast_pkg::is_alpha(c) || c == ast_pkg::CH_UNDER || c == ast_pkg::CH_DOT) begin
          mode_d = ast_pkg::M_IDENT;
          for (int i = 0; i < 8; i++) begin
            if (ast_pkg::kw_char(3'(i), 3'd0) != c) kcand_d[i] = 1'b0;
          end
          rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_IDENT, c, start_d, 6'd0};
          n = n + 3'd1;
          klen_d = klen_d + 1'b1;
        end else if (c == ast_pkg::CH_LF) begin
          rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_NEWLINE, ast_pkg::CH_BSL, start_d, 6'd0};
          n = n + 3'd1;
          klen_d = klen_d + 1'b1;
          if (klen_d < KEEP_MAX) begin
            rec_d[n] = '{ast_pkg::REC_TEXT, ast_pkg::TK_NEWLINE, ast_pkg::CH_LOWN,
                         start_d, 6'd0};
            n = n + 3'd1;
            klen_d = klen_d + 1'b1;
          end
          rec_d[n] = '{ast_pkg::REC_DONE, ast_pkg::TK_NEWLINE, 8'd0, start_d, 6'(klen_d)};
          n = n + 3'd1;
          if (line_d != '1) line_d = line_d + 32'd1;
        end else begin
          tt = (c == ast_pkg::CH_COMMA) ? ast_pkg::TK_COMMA :
               (c == ast_pkg::CH_COLON) ? ast_pkg::TK_COLON : ast_pkg::TK_IDENT;
          rec_d[n] = '{ast_pkg::REC_TEXT, tt, c, start_d, 6'd0};
          n = n + 3'd1;
          klen_d = klen_d + 1'b1;
          rec_d[n] = '{ast_pkg::REC_DONE, tt, 8'd0, start_d, 6'(klen_d)};
          n = n + 3'd1;
        end
      end
    end
    cnt_d = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ast_pkg::M_IDLE;
      quote_q <= 1'b0;
      line_q  <= 32'd1;
      start_q <= 32'd1;
      klen_q  <= '0;
      kcand_q <= 8'hFF;
      num_q   <= '0;
      cnt_q   <= 3'd0;
      idx_q   <= 3'd0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
      line_q  <= line_d;
      start_q <= start_d;
      klen_q  <= klen_d;
      kcand_q <= kcand_d;
      num_q   <= num_d;
      cnt_q   <= cnt_d;
      idx_q   <= 3'd0;
    end else if (out_fire) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rec_q <= rec_d;
      val_q <= val_d;
    end
  end

  ast_pkg::rec_t cur;
  assign cur = (idx_q < 3'(NREC)) ? rec_q[idx_q] : '0;

  assign record_kind_o  = cur.kind;
  assign token_type_o   = cur.ttype;
  assign text_byte_o    = cur.text;
  assign token_line_o   = cur.line;
  assign text_length_o  = cur.len;
  assign number_value_o = (cur.kind == ast_pkg::REC_DONE && cur.ttype == ast_pkg::TK_NUMBER)
                          ? val_q : 64'sd0;
  assign last_of_run_o  = at_last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(NREC))
    else $error("record count exceeds buffer");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != 32'd0)
    else $error("line counter wrapped to zero");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && source_byte_i == ast_pkg::CH_NUL |=>
      cnt_q != 3'd0 && rec_q[cnt_q - 3'd1].kind == ast_pkg::REC_DONE &&
      rec_q[cnt_q - 3'd1].ttype == ast_pkg::TK_EOF)
    else $error("end of source beat did not close with an eof record");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !at_last |=> out_valid_o)
    else $error("record buffer dropped pending records");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the assembly source tokenizer.
module tb_top;

  typedef struct packed {
    logic        kind;
    logic [2:0]  ttype;
    logic [7:0]  text;
    logic [31:0] line;
    logic [63:0] value;
    logic [5:0]  len;
    logic        last;
  } tok_rec_t;

  localparam int CAP = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [7:0] source_byte_i = 8'h00;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, record_kind_o, last_of_run_o;
  logic [2:0] token_type_o;
  logic [7:0] text_byte_o;
  logic [31:0] token_line_o;
  logic signed [63:0] number_value_o;
  logic [5:0] text_length_o;

  assembly_source_tokenizer #(.TEXT_CAPACITY(CAP)) dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // scanner shadow state
  ast_pkg::scan_mode_e sc_mode;
  logic        sc_single;
  logic [31:0] sc_line, sc_start;
  int unsigned sc_kept;
  logic [7:0]  sc_cand;
  logic [63:0] sc_acc;
  logic [2:0]  sc_phase;
  logic        sc_neg, sc_stop, sc_ovf;

  tok_rec_t expected_recs[$];
  tok_rec_t step_recs[$];
  int errors = 0;
  int bytes_sent = 0;
  int recs_seen = 0;
  int send_idle = 0;
  int recv_idle = 0;

  string kw_names[8] = '{"global", "section", "db", "extern", "resb", "resw", "resd", "resq"};

  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic bit alp(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic int hexv(logic [7:0] c);
    if (dig(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic void put(logic kind, logic [2:0] ty, logic [7:0] b, logic [63:0] v,
                              int unsigned n);
    tok_rec_t r;
    r.kind = kind; r.ttype = ty; r.text = b; r.line = sc_start;
    r.value = v; r.len = n[5:0]; r.last = 1'b0;
    step_recs.push_back(r);
  endfunction

  function automatic void bump_line();
    if (sc_line != 32'hFFFF_FFFF) sc_line++;
  endfunction

  function automatic void keep(logic [2:0] ty, logic [7:0] c);
    if (sc_kept >= CAP - 1) return;
    put(ast_pkg::REC_TEXT, ty, c, 0, 0);
    sc_kept++;
  endfunction

  function automatic void accum(int base, int d);
    logic [67:0] w, lim;
    if (sc_ovf) return;
    w = {4'b0, sc_acc} * base + d;
    lim = sc_neg ? {4'b0, ast_pkg::NEG_LIMIT} : {4'b0, ast_pkg::POS_LIMIT};
    if (w > lim) sc_ovf = 1'b1;
    else sc_acc = w[63:0];
  endfunction

  function automatic void num_byte(logic [7:0] c);
    int d;
    d = hexv(c);
    if (sc_kept >= CAP - 1) return;
    put(ast_pkg::REC_TEXT, ast_pkg::TK_NUMBER, c, 0, 0);
    sc_kept++;
    if (sc_stop) return;
    case (sc_phase)
      3'd0: if (c == "0") sc_phase = 1;
            else if (d < 10) begin sc_phase = 3; accum(10, d); end
            else sc_stop = 1;
      3'd1: if (c == "x" || c == "X") sc_phase = 2;
            else if (d < 8) begin sc_phase = 4; accum(8, d); end
            else sc_stop = 1;
      3'd2: if (d < 16) begin sc_phase = 5; accum(16, d); end else sc_stop = 1;
      3'd3: if (d < 10) accum(10, d); else sc_stop = 1;
      3'd4: if (d < 8) accum(8, d); else sc_stop = 1;
      default: if (d < 16) accum(16, d); else sc_stop = 1;
    endcase
  endfunction

  function automatic void ident_byte(logic [7:0] c);
    string w;
    if (sc_kept >= CAP - 1) return;
    for (int i = 0; i < 8; i++) begin
      w = kw_names[i];
      if (sc_kept >= w.len() || w[sc_kept] != c) sc_cand[i] = 1'b0;
    end
    put(ast_pkg::REC_TEXT, ast_pkg::TK_IDENT, c, 0, 0);
    sc_kept++;
  endfunction

  function automatic void open_token(ast_pkg::scan_mode_e m);
    sc_mode = m; sc_start = sc_line; sc_kept = 0; sc_cand = 8'hFF;
    sc_acc = 0; sc_phase = 0; sc_neg = 0; sc_stop = 0; sc_ovf = 0;
  endfunction

  function automatic void close_number();
    logic [63:0] v;
    if (sc_ovf) v = sc_neg ? ast_pkg::NEG_LIMIT : ast_pkg::POS_LIMIT;
    else v = sc_neg ? -sc_acc : sc_acc;
    put(ast_pkg::REC_DONE, ast_pkg::TK_NUMBER, 0, v, sc_kept);
    sc_mode = ast_pkg::M_IDLE;
  endfunction

  function automatic void close_ident();
    bit dir;
    string w;
    dir = 0;
    for (int i = 0; i < 8; i++) begin
      w = kw_names[i];
      if (sc_cand[i] && w.len() == sc_kept) dir = 1;
    end
    put(ast_pkg::REC_DONE, dir ? ast_pkg::TK_DIRECT : ast_pkg::TK_IDENT, 0, 0, sc_kept);
    sc_mode = ast_pkg::M_IDLE;
  endfunction

  function automatic void single_token(logic [2:0] ty, logic [7:0] a, logic [7:0] b, int n);
    open_token(ast_pkg::M_IDLE);
    keep(ty, a);
    if (n > 1) keep(ty, b);
    put(ast_pkg::REC_DONE, ty, 0, 0, sc_kept);
  endfunction

  function automatic void between_tokens(logic [7:0] c);
    sc_mode = ast_pkg::M_IDLE;
    if (c == ast_pkg::CH_NUL) begin
      sc_start = sc_line;
      put(ast_pkg::REC_DONE, ast_pkg::TK_EOF, 0, 0, 0);
    end else if (c == ast_pkg::CH_SPACE || c == ast_pkg::CH_TAB || c == ast_pkg::CH_CR) begin
    end else if (c == ast_pkg::CH_SEMI) sc_mode = ast_pkg::M_COMMENT;
    else if (c == ast_pkg::CH_LF) begin
      single_token(ast_pkg::TK_NEWLINE, ast_pkg::CH_BSL, ast_pkg::CH_LOWN, 2);
      bump_line();
    end else if (c == ast_pkg::CH_COMMA) single_token(ast_pkg::TK_COMMA, c, 0, 1);
    else if (c == ast_pkg::CH_COLON) single_token(ast_pkg::TK_COLON, c, 0, 1);
    else if (c == ast_pkg::CH_DQUOT || c == ast_pkg::CH_SQUOT) begin
      open_token(ast_pkg::M_STRING);
      sc_single = (c == ast_pkg::CH_SQUOT);
    end else if (dig(c)) begin
      open_token(ast_pkg::M_NUMBER);
      num_byte(c);
    end else if (c == ast_pkg::CH_MINUS) open_token(ast_pkg::M_MINUS);
    else if (alp(c) || c == ast_pkg::CH_UNDER || c == ast_pkg::CH_DOT) begin
      open_token(ast_pkg::M_IDENT);
      ident_byte(c);
    end else single_token(ast_pkg::TK_IDENT, c, 0, 1);
  endfunction

  // Predicts the records one source byte causes and queues them.
  function automatic void tokenize_byte(logic [7:0] c);
    logic [7:0] e;
    step_recs.delete();
    case (sc_mode)
      ast_pkg::M_COMMENT: if (c == ast_pkg::CH_LF || c == ast_pkg::CH_NUL) between_tokens(c);
      ast_pkg::M_STRING: begin
        if (c == (sc_single ? ast_pkg::CH_SQUOT : ast_pkg::CH_DQUOT)) begin
          put(ast_pkg::REC_DONE, ast_pkg::TK_STRING, 0, 0, sc_kept);
          sc_mode = ast_pkg::M_IDLE;
        end else if (c == ast_pkg::CH_NUL) begin
          put(ast_pkg::REC_DONE, ast_pkg::TK_STRING, 0, 0, sc_kept);
          between_tokens(ast_pkg::CH_NUL);
        end else if (c == ast_pkg::CH_BSL) sc_mode = ast_pkg::M_ESCAPE;
        else begin
          keep(ast_pkg::TK_STRING, c);
          if (c == ast_pkg::CH_LF) bump_line();
        end
      end
      ast_pkg::M_ESCAPE: begin
        if (c == ast_pkg::CH_NUL) begin
          keep(ast_pkg::TK_STRING, 0);
          put(ast_pkg::REC_DONE, ast_pkg::TK_STRING, 0, 0, sc_kept);
          between_tokens(ast_pkg::CH_NUL);
        end else begin
          e = c;
          if (c == ast_pkg::CH_LOWN) e = ast_pkg::CH_LF;
          else if (c == ast_pkg::CH_LOWT) e = ast_pkg::CH_TAB;
          else if (c == ast_pkg::CH_LOWR) e = ast_pkg::CH_CR;
          else if (c == ast_pkg::CH_ZERO) e = ast_pkg::CH_NUL;
          keep(ast_pkg::TK_STRING, e);
          if (c == ast_pkg::CH_LF) bump_line();
          sc_mode = ast_pkg::M_STRING;
        end
      end
      ast_pkg::M_MINUS: begin
        if (dig(c)) begin
          sc_mode = ast_pkg::M_NUMBER;
          sc_neg = 1;
          keep(ast_pkg::TK_NUMBER, ast_pkg::CH_MINUS);
          num_byte(c);
        end else begin
          keep(ast_pkg::TK_IDENT, ast_pkg::CH_MINUS);
          put(ast_pkg::REC_DONE, ast_pkg::TK_IDENT, 0, 0, sc_kept);
          between_tokens(c);
        end
      end
      ast_pkg::M_NUMBER:
        if (hexv(c) < 16 || c == ast_pkg::CH_LOWX || c == ast_pkg::CH_UPX) num_byte(c);
        else begin close_number(); between_tokens(c); end
      ast_pkg::M_IDENT:
        if (alp(c) || dig(c) || c == ast_pkg::CH_UNDER || c == ast_pkg::CH_DOT) ident_byte(c);
        else begin close_ident(); between_tokens(c); end
      default: between_tokens(c);
    endcase
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
    foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
  endfunction

  task automatic send_byte(logic [7:0] c);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    source_byte_i <= c;
    @(posedge clk_i iff in_ready_o);
    tokenize_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_recs.size() > 0) @(posedge clk_i);
  endtask

  // receiver: random stalls and checking
  always @(posedge clk_i) begin
    tok_rec_t x;
    if (out_valid_o && out_ready_i) begin
      recs_seen++;
      if (expected_recs.size() == 0) begin
        $error("unexpected record kind=%0d type=%0d", record_kind_o, token_type_o);
        errors++;
      end else begin
        x = expected_recs.pop_front();
        if (record_kind_o !== x.kind) begin
          $error("record_kind exp %0d got %0d", x.kind, record_kind_o); errors++; end
        if (token_type_o !== x.ttype) begin
          $error("token_type exp %0d got %0d", x.ttype, token_type_o); errors++; end
        if (text_byte_o !== x.text) begin
          $error("text_byte exp %h got %h", x.text, text_byte_o); errors++; end
        if (token_line_o !== x.line) begin
          $error("token_line exp %0d got %0d", x.line, token_line_o); errors++; end
        if (number_value_o !== x.value) begin
          $error("number_value exp %0d got %0d", $signed(x.value), number_value_o);
          errors++;
        end
        if (text_length_o !== x.len) begin
          $error("text_length exp %0d got %0d", x.len, text_length_o); errors++; end
        if (last_of_run_o !== x.last) begin
          $error("last_of_run exp %0d got %0d", x.last, last_of_run_o); errors++; end
      end
    end
    out_ready_i <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  task automatic test_punctuation();
    send_text("global section: db, extern\n");
    send_text("  resb\tresw\rresd resq ; c ,\n");
    send_text("globalx _a.b9 \x01\x0c\x0b\x7f\xff\x80 -x -");
  endtask

  task automatic test_numbers();
    send_text("0 0x1F -0X7fff 0777 089 12ab 9223372036854775808\n");
    send_text("-9223372036854775808 -9223372036854775809 0x 0xg 1x ");
  endtask

  task automatic test_strings();
    send_text("\"a\\n\\t\\r\\0\\q\\\"\" 'x\"\n' \"\\");
    send_byte(ast_pkg::CH_NUL); // escape at end of source
    send_text("\"open");
    send_byte(ast_pkg::CH_NUL);
    send_text("abc");
    send_byte(ast_pkg::CH_NUL);
  endtask

  task automatic test_long_tokens();
    string s;
    s = "";
    for (int i = 0; i < 65; i++) s = {s, "7"};
    send_text({s, " "});
  endtask

  function automatic string rand_word();
    string s;
    int n;
    case ($urandom_range(7))
      0: return kw_names[$urandom_range(7)];
      1: begin
        s = "";
        if ($urandom_range(1)) s = "-";
        n = $urandom_range(1, 6);
        if ($urandom_range(1)) s = {s, "0x"};
        for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
        return s;
      end
      2: begin
        s = "'";
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(32, 126)))};
        return {s, "\"'"};
      end
      3: return ", ";
      4: return ": ";
      5: return "\n";
      6: return "; note\n";
      default: begin
        s = "";
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) s = {s, string'(8'("a" + $urandom_range(25)))};
        return {s, " "};
      end
    endcase
  endfunction

  task automatic test_random(int count);
    int start;
    logic [7:0] b;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      if ($urandom_range(9) < 8) send_text(rand_word());
      else begin
        b = $urandom_range(1, 255);
        send_byte(b);
      end
      if ($urandom_range(40) == 0) begin
        send_byte(8'h00);
        send_byte(8'hFF);
      end
    end
  endtask

  initial begin
    sc_mode = ast_pkg::M_IDLE; sc_single = 0; sc_line = 1; sc_start = 1; sc_kept = 0;
    sc_cand = 8'hFF; sc_acc = 0; sc_phase = 0; sc_neg = 0; sc_stop = 0; sc_ovf = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_punctuation();
    test_numbers();
    test_strings();
    test_long_tokens();
    send_idle = 24; recv_idle = 64;
    test_random(15);
    wait_drained(); // sender holds off until every record is back
    send_idle = 64; recv_idle = 24;
    test_random(15);
    send_idle = 0; recv_idle = 0;
    test_random(15);
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d source bytes, checked %0d records (punctuation, numbers,", bytes_sent,
             recs_seen);
    $display("strings, escapes, long tokens, end of source, random streams).");
    if (errors == 0 && expected_recs.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #100000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
